@@ rtl/core/bpfa_pkg.sv @@
// Shared types and constants of the bitmap page frame allocator.
`default_nettype none
package bpfa_pkg;

    localparam int ADDR_W   = 48;
    localparam int COUNT_W  = 13;
    localparam int WORD_W   = 64;   // bitmap bits per memory word
    localparam int BIT_W    = 6;    // log2(WORD_W)
    localparam int PAGE_SH  = 12;   // log2 of the 4096-byte frame
    localparam int IDX_W    = ADDR_W - PAGE_SH;

    // action codes
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_OUTSIDE = 2'd2;

    // configuration register indexes
    localparam logic CFG_REGION_BASE = 1'b0;
    localparam logic CFG_FRAME_COUNT = 1'b1;

    typedef struct packed {
        logic       clr_wr;      // clearing sweep writes one word
        logic       take_item;   // capture the accepted input transaction
        logic       rd_free;     // read the word of the freed frame
        logic       rd_alloc;    // read the word at the scan pointer
        logic       hint_inc;    // word is full, move the scan pointer on
        logic       wr_free;     // write back the word with the bit cleared
        logic       wr_alloc;    // write back the word with the bit set
        logic       res_load;    // latch the result of this item
        logic [1:0] res_status;
        logic       res_alloc;   // result carries an allocated address
        logic       out_load;    // move result into the output register
    } t_bpfa_cmd;

    typedef struct packed {
        logic clr_last;      // last word of the clearing sweep
        logic free_outside;  // freed address outside the usable region
        logic alloc_none;    // scan pointer already past the usable count
        logic word_full;     // every bit of the read word is used
        logic word_spent;    // no free bit below the usable count in the word
    } t_bpfa_sts;

endpackage
`default_nettype wire

@@ rtl/core/bpfa_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module bpfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ rtl/core/bpfa_dp.sv @@
// Datapath: configuration, bitmap memory, scan pointer, address arithmetic, output register.
`default_nettype none
module bpfa_dp #(
    parameter int MAX_FRAMES = 4096
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic                           i_cfg_idx,
    input  wire logic [bpfa_pkg::ADDR_W-1:0]    i_cfg_wdata,
    input  wire logic [bpfa_pkg::ADDR_W-1:0]    i_free_address,
    input  wire bpfa_pkg::t_bpfa_cmd            i_cmd,
    output bpfa_pkg::t_bpfa_sts                 o_sts,
    output logic      [bpfa_pkg::ADDR_W-1:0]    o_frame_address,
    output logic      [1:0]                     o_status
);
    import bpfa_pkg::*;

    localparam int NWORDS = (MAX_FRAMES + WORD_W - 1) / WORD_W;
    localparam int WIW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int HW     = $clog2(NWORDS + 1);
    localparam int FW     = $clog2(MAX_FRAMES) + 1;
    localparam int LW     = (COUNT_W > FW) ? COUNT_W : FW;

    // configuration
    logic [ADDR_W-1:0]  r_base;
    logic [COUNT_W-1:0] r_count;
    logic [LW-1:0]      limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_count <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_REGION_BASE: r_base  <= i_cfg_wdata;
                CFG_FRAME_COUNT: r_count <= i_cfg_wdata[COUNT_W-1:0];
                default:         r_base  <= r_base;
            endcase
        end
    end

    assign limit = (32'(r_count) > 32'(MAX_FRAMES)) ? LW'(MAX_FRAMES) : LW'(r_count);

    // captured item and control counters
    logic [ADDR_W-1:0] r_faddr;
    logic [WIW-1:0]    r_clr;
    logic [HW-1:0]     r_hint;   // every word below it is all used
    logic [WIW-1:0]    r_fword;
    logic [BIT_W-1:0]  r_fbit;
    logic [BIT_W-1:0]  r_sel;
    logic [1:0]        r_res_status;
    logic              r_res_alloc;
    logic [ADDR_W-1:0] r_out_addr;
    logic [1:0]        r_out_status;

    // free path: offset from base and frame index
    logic [ADDR_W-1:0] offset;
    logic [IDX_W-1:0]  fidx;
    logic              below;

    assign below  = r_faddr < r_base;
    assign offset = r_faddr - r_base;
    assign fidx   = offset[ADDR_W-1:PAGE_SH];

    // allocate path: word mask and lowest free bit
    logic [WORD_W-1:0] rdata;
    logic [31:0]       start;
    logic [31:0]       rem;
    logic [WORD_W-1:0] masked;
    logic [BIT_W-1:0]  sel;
    logic              found;

    assign start = 32'({r_hint, BIT_W'(0)});
    assign rem   = 32'(limit) - start;

    always_comb begin
        for (int b = 0; b < WORD_W; b++) begin
            masked[b] = rdata[b] | (rem <= 32'(b));
        end
    end

    always_comb begin
        sel   = '0;
        found = 1'b0;
        for (int b = 0; b < WORD_W; b++) begin
            if (!masked[b] && !found) begin
                sel   = BIT_W'(b);
                found = 1'b1;
            end
        end
    end

    // memory ports
    logic              we;
    logic [WIW-1:0]    waddr;
    logic [WORD_W-1:0] wdata;
    logic              re;
    logic [WIW-1:0]    raddr;

    always_comb begin
        we    = i_cmd.clr_wr | i_cmd.wr_free | i_cmd.wr_alloc;
        waddr = r_clr;
        wdata = '0;
        if (i_cmd.wr_free) begin
            waddr = r_fword;
            wdata = rdata & ~(WORD_W'(1) << r_fbit);
        end else if (i_cmd.wr_alloc) begin
            waddr = r_hint[WIW-1:0];
            wdata = rdata | (WORD_W'(1) << sel);
        end
        re    = i_cmd.rd_free | i_cmd.rd_alloc;
        raddr = i_cmd.rd_free ? fidx[WIW+BIT_W-1:BIT_W] : r_hint[WIW-1:0];
    end

    bpfa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NWORDS),
        .AW    (WIW)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_hint <= '0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + WIW'(1);
            end
            if (i_cmd.hint_inc) begin
                r_hint <= r_hint + HW'(1);
            end else if (i_cmd.wr_free && (HW'(r_fword) < r_hint)) begin
                r_hint <= HW'(r_fword);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_item) begin
            r_faddr <= i_free_address;
        end
        if (i_cmd.rd_free) begin
            r_fword <= fidx[WIW+BIT_W-1:BIT_W];
            r_fbit  <= fidx[BIT_W-1:0];
        end
        if (i_cmd.wr_alloc) begin
            r_sel <= sel;
        end
        if (i_cmd.res_load) begin
            r_res_status <= i_cmd.res_status;
            r_res_alloc  <= i_cmd.res_alloc;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_addr   <= r_res_alloc
                ? r_base + ADDR_W'({r_hint[WIW-1:0], r_sel, PAGE_SH'(0)})
                : '0;
        end
    end

    assign o_sts.clr_last     = (32'(r_clr) == 32'(NWORDS - 1));
    assign o_sts.free_outside = below || (fidx >= IDX_W'(limit));
    assign o_sts.alloc_none   = start >= 32'(limit);
    assign o_sts.word_full    = &rdata;
    assign o_sts.word_spent   = !found;

    assign o_frame_address = r_out_addr;
    assign o_status        = r_out_status;

endmodule
`default_nettype wire

@@ rtl/core/bpfa_ctrl.sv @@
// Controller: sequences the clearing sweep, allocate scan, free and result hand-off.
`default_nettype none
module bpfa_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_action,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    input  wire bpfa_pkg::t_bpfa_sts  i_sts,
    output bpfa_pkg::t_bpfa_cmd       o_cmd
);
    import bpfa_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FCHK,
        S_FWAIT,
        S_AREAD,
        S_AEVAL,
        S_RESULT
    } t_state;

    t_state    r_state, n_state;
    logic      r_out_valid, n_out_valid;
    t_bpfa_cmd cmd;
    logic      out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        cmd         = '0;
        unique case (r_state)
            S_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.take_item = 1'b1;
                    n_state = (i_in_action == ACT_FREE) ? S_FCHK : S_AREAD;
                end
            end
            S_FCHK: begin
                if (i_sts.free_outside) begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_OUTSIDE;
                    n_state        = S_RESULT;
                end else begin
                    cmd.rd_free = 1'b1;
                    n_state     = S_FWAIT;
                end
            end
            S_FWAIT: begin
                cmd.wr_free    = 1'b1;
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_DONE;
                n_state        = S_RESULT;
            end
            S_AREAD: begin
                if (i_sts.alloc_none) begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_FULL;
                    n_state        = S_RESULT;
                end else begin
                    cmd.rd_alloc = 1'b1;
                    n_state      = S_AEVAL;
                end
            end
            S_AEVAL: begin
                if (i_sts.word_full) begin
                    cmd.hint_inc = 1'b1;
                    n_state      = S_AREAD;
                end else if (i_sts.word_spent) begin
                    // free bits only above the usable count
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_FULL;
                    n_state        = S_RESULT;
                end else begin
                    cmd.wr_alloc   = 1'b1;
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_DONE;
                    cmd.res_alloc  = 1'b1;
                    n_state        = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

@@ rtl/core/bitmap_page_frame_allocator.sv @@
// Bitmap first-fit page frame allocator: top level.
//
// Requests enter on the s_axis channel: tuser is the action (allocate or
// free), tdata the 48-bit address to free. Each request gives exactly one
// transaction on m_axis: tdata the 48-bit frame address (zero on free or
// error), tuser the 2-bit status. The user must see that region_base and
// frame_count are written through the plain cfg port while no request is
// in flight; the block itself does not enforce this. The bitmap sits in
// 64-bit RAM words behind a scan pointer below which every word is
// fully used. An allocate runs the read and evaluate states, again for
// each full word the pointer steps over, then the result state; a free
// runs the check, wait and result states. A request refused before any
// bitmap read (pointer past the count, or freed address outside) goes
// straight to the result state. One request is worked on at a time: a
// new one is taken only after the last has left the result state.
// Results sit in an output register, so a new request is accepted while
// the previous result waits for tready; a stalled receiver holds the
// block once the next result is ready. After reset the controller
// sweeps the bitmap to zero, one word per cycle, with tready low meanwhile.
`default_nettype none
module bitmap_page_frame_allocator #(
    parameter int MAX_FRAMES = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [47:0] i_s_axis_tdata,   // [47:0] free_address
    input  wire logic        i_s_axis_tuser,   // [0] action
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [47:0] o_m_axis_tdata,   // [47:0] frame_address
    output logic      [1:0]  o_m_axis_tuser,   // [1:0] status
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [47:0] i_cfg_wdata
);
    import bpfa_pkg::*;

    t_bpfa_cmd cmd;
    t_bpfa_sts sts;

    bpfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_action (i_s_axis_tuser),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bpfa_dp #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_free_address  (i_s_axis_tdata),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_frame_address (o_m_axis_tdata),
        .o_status        (o_m_axis_tuser)
    );

endmodule
`default_nettype wire

@@ tb/bitmap_page_frame_allocator_tb.sv @@
// Self-checking testbench for the bitmap page frame allocator.
module bitmap_page_frame_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bpfa_pkg::*;

    localparam int FRAME_SLOTS = 4096;

    typedef struct packed {
        logic [47:0] frame_addr;
        logic [1:0]  status;
    } t_alloc_reply;

    // Shadow bitmap plus the queue of replies still owed by the block.
    class t_alloc_ledger;
        bit           frame_taken[FRAME_SLOTS];
        logic [47:0]  region_base;
        logic [12:0]  frame_count;
        t_alloc_reply owed[$];
        int           mismatches;
        int           granted;
        int           refused_full;
        int           refused_outside;
        int           released;

        function new();
            region_base = '0;
            frame_count = '0;
            foreach (frame_taken[i]) frame_taken[i] = 1'b0;
            mismatches = 0;
            granted = 0;
            refused_full = 0;
            refused_outside = 0;
            released = 0;
        endfunction

        function int unsigned usable();
            if (frame_count > FRAME_SLOTS) return FRAME_SLOTS;
            return 32'(frame_count);
        endfunction

        function void set_reg(logic idx, logic [47:0] value);
            if (idx == CFG_REGION_BASE) region_base = value;
            else frame_count = value[12:0];
        endfunction

        function void note_request(logic act, logic [47:0] addr);
            t_alloc_reply r;
            int unsigned  lim;
            int unsigned  i;
            logic [47:0]  slot;
            r.frame_addr = '0;
            r.status = ST_DONE;
            lim = usable();
            if (act == ACT_ALLOC) begin
                r.status = ST_FULL;
                for (i = 0; i < lim; i++) begin
                    if (!frame_taken[i]) begin
                        frame_taken[i] = 1'b1;
                        r.frame_addr = region_base + (48'(i) << 12);
                        r.status = ST_DONE;
                        break;
                    end
                end
                if (r.status == ST_DONE) granted++;
                else refused_full++;
            end else if (addr < region_base) begin
                r.status = ST_OUTSIDE;
                refused_outside++;
            end else begin
                slot = (addr - region_base) >> 12;
                if (slot >= 48'(lim)) begin
                    r.status = ST_OUTSIDE;
                    refused_outside++;
                end else begin
                    frame_taken[slot[11:0]] = 1'b0;
                    released++;
                end
            end
            owed.push_back(r);
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        task check_result(logic [47:0] addr, logic [1:0] st);
            t_alloc_reply w;
            if (owed.size() == 0) begin
                report($sformatf("reply with nothing owed: addr %h status %0d", addr, st));
                return;
            end
            w = owed.pop_front();
            if (st !== w.status)
                report($sformatf("status %0d, wanted %0d", st, w.status));
            if (addr !== w.frame_addr)
                report($sformatf("frame address %h, wanted %h", addr, w.frame_addr));
        endtask

        // Random frame that is handed out and still below the usable count.
        function bit pick_taken(output int unsigned idx);
            int unsigned lim;
            int unsigned n;
            int unsigned k;
            int unsigned i;
            lim = usable();
            n = 0;
            idx = 0;
            for (i = 0; i < lim; i++) if (frame_taken[i]) n++;
            if (n == 0) return 1'b0;
            k = $urandom_range(0, n - 1);
            for (i = 0; i < lim; i++) begin
                if (frame_taken[i]) begin
                    if (k == 0) begin
                        idx = i;
                        return 1'b1;
                    end
                    k--;
                end
            end
            return 1'b0;
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [47:0] i_s_axis_tdata;   // [47:0] free_address
    logic        i_s_axis_tuser;   // [0] action
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [47:0] o_m_axis_tdata;   // [47:0] frame_address
    logic [1:0]  o_m_axis_tuser;   // [1:0] status
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [47:0] i_cfg_wdata;

    t_alloc_ledger ledger;
    logic          calm;
    int            hold_cycles;
    int            settings_written;

    bitmap_page_frame_allocator #(
        .MAX_FRAMES(FRAME_SLOTS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Replies are checked before the request of the same edge is noted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready)
                ledger.check_result(o_m_axis_tdata, o_m_axis_tuser);
            if (i_s_axis_tvalid && o_s_axis_tready)
                ledger.note_request(i_s_axis_tuser, i_s_axis_tdata);
        end
    end

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [47:0] rand48();
        logic [63:0] t;
        t = {$urandom, $urandom};
        return t[47:0];
    endfunction

    function automatic logic [47:0] pick_free_addr();
        int unsigned idx;
        int unsigned lim;
        logic [47:0] off;
        int          r;
        lim = ledger.usable();
        off = 48'($urandom_range(0, 4095));
        r = $urandom_range(0, 9);
        if (r <= 5 && ledger.pick_taken(idx))
            return ledger.region_base + (48'(idx) << 12) + off;
        // possibly already free: double release
        if (r == 6 && lim > 0)
            return ledger.region_base + (48'($urandom_range(0, lim - 1)) << 12) + off;
        if (r == 7)
            return ledger.region_base - 48'($urandom_range(1, 4096));
        if (r == 8)
            return ledger.region_base + (48'(lim) << 12) + off;
        return rand48();
    endfunction

    // Receiver: random back-pressure, or a long hold-off on request.
    initial begin
        int n;
        i_m_axis_tready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                n = hold_cycles;
                hold_cycles = 0;
                i_m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    task automatic send_request(input logic act, input logic [47:0] addr);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= act;
        i_s_axis_tdata  <= addr;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (ledger.owed.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes both registers on consecutive edges; only call while idle.
    task automatic write_config(input logic [47:0] base, input logic [47:0] count);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_REGION_BASE;
        i_cfg_wdata <= base;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_FRAME_COUNT;
        i_cfg_wdata <= count;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        ledger.set_reg(CFG_REGION_BASE, base);
        ledger.set_reg(CFG_FRAME_COUNT, count);
        settings_written++;
    endtask

    initial begin : main
        logic [47:0] b;
        logic [47:0] cnt;
        int          pct;
        int          r;
        ledger = new();
        calm = 1'b0;
        hold_cycles = 0;
        settings_written = 0;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = ACT_ALLOC;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_REGION_BASE;
        i_cfg_wdata = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: no frames at all.
        send_request(ACT_ALLOC, 48'h0);
        send_request(ACT_FREE, 48'h0);
        send_request(ACT_FREE, 48'hFFFF_FFFF_FFFF);
        drain();

        // Base near the top so the third frame wraps past 2^48.
        b = 48'hFFFF_FFFF_E000;
        write_config(b, 48'd3);
        repeat (4) send_request(ACT_ALLOC, rand48());
        send_request(ACT_FREE, b + 48'h1123);
        send_request(ACT_FREE, b + 48'h1123);
        send_request(ACT_FREE, 48'h0000_0000_0800);
        send_request(ACT_ALLOC, 48'hFFFF_FFFF_FFFF);
        send_request(ACT_FREE, 48'hFFFF_FFFF_FFFF);
        drain();

        // Count above capacity, then shrunk and grown again.
        b = 48'h0000_8000_0000;
        write_config(b, 48'd8191);
        repeat (6) send_request(ACT_ALLOC, 48'h0);
        send_request(ACT_FREE, b + (48'd4095 << 12));
        send_request(ACT_FREE, b + (48'd4096 << 12));
        drain();
        write_config(b, 48'd2);
        send_request(ACT_ALLOC, 48'h0);
        send_request(ACT_FREE, b + (48'd4 << 12) + 48'hFFF);
        send_request(ACT_FREE, b + 48'h7);
        send_request(ACT_ALLOC, 48'h0);
        drain();
        write_config(b, 48'd8);
        send_request(ACT_ALLOC, 48'h0);

        for (int ph = 0; ph < 6; ph++) begin
            drain();
            r = $urandom_range(0, 3);
            case (r)
                0: b = 48'h0;
                1: b = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 20) << 12);
                2: b = rand48();
                default: b = rand48() & 48'hFFFF_FFFF_F000;
            endcase
            r = $urandom_range(0, 9);
            case (r)
                0: cnt = 48'd0;
                1: cnt = 48'd4096;
                2: cnt = 48'd8191;
                3: cnt = 48'($urandom_range(0, 8191));
                default: cnt = 48'($urandom_range(1, 64));
            endcase
            write_config(b, cnt);
            calm = (ph == 2 || ph == 3);
            pct = $urandom_range(35, 80);
            // receiver holds off while requests keep coming
            if (ph == 3) hold_cycles = 300;
            for (int k = 0; k < 100; k++) begin
                if (ph == 4 && k == 50) drain();
                if ($urandom_range(1, 100) <= pct) send_request(ACT_ALLOC, rand48());
                else send_request(ACT_FREE, pick_free_addr());
            end
        end
        calm = 1'b0;
        drain();
        repeat (10) @(posedge i_clk);

        $display("run covered %0d frames granted, %0d refused as full, %0d released",
                 ledger.granted, ledger.refused_full, ledger.released);
        $display("and %0d frees outside the region over %0d register settings",
                 ledger.refused_outside, settings_written);
        if (ledger.mismatches == 0 && ledger.owed.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/bpfa_pkg.sv
rtl/core/bpfa_ram.sv
rtl/core/bpfa_dp.sv
rtl/core/bpfa_ctrl.sv
rtl/core/bitmap_page_frame_allocator.sv
tb/bitmap_page_frame_allocator_tb.sv
